@@ rtl/isettab_pkg.sv @@
// ----------------------------------------------------------------------------
// isettab_pkg - integer set table shared definitions
// Sizes, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package isettab_pkg;

    // store size and derived widths
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // item field widths
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 10;
    localparam int ELEM_W = 11;

    // operation codes (unused code acts as lookup)
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ rtl/integer_set_table.sv @@
// Sequence: the search reads one store entry per cycle and stops at the first hit;
//   a miss reads every live entry, and a remove that hits then shifts the entries
//   above it down. One item is in work at a time: no new request is taken until
//   the result of the last one has been handed to the output register.
// Reset: count and control clear at once; store contents stay undefined.
// ----------------------------------------------------------------------------
// integer_set_table - ordered set of distinct 32-bit values
// Linear search over a store with one read and one write port, append on add, order-keeping
// shift-down on remove. One result item per request item.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // request channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [isettab_pkg::OP_W-1:0]           opcode,
    input  wire logic signed [isettab_pkg::VAL_W-1:0]   value,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [isettab_pkg::STAT_W-1:0]              status,
    output logic                                        found,
    output logic [isettab_pkg::POS_W-1:0]               position,
    output logic [isettab_pkg::ELEM_W-1:0]              element_count
);

    localparam int ADDR_W = isettab_pkg::ADDR_W;
    localparam int CNT_W  = isettab_pkg::CNT_W;
    localparam int VAL_W  = isettab_pkg::VAL_W;

    // element store: one write and one registered read per cycle
    logic [VAL_W-1:0] mem [isettab_pkg::DEPTH];
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0] rd_data_reg;

    // control state
    isettab_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_pend_reg, rd_pend_next;

    // item and working registers
    logic [isettab_pkg::OP_W-1:0]   opcode_reg, opcode_next;
    logic [VAL_W-1:0]               value_reg, value_next;
    logic [CNT_W-1:0]               scan_reg, scan_next;      // next address to read
    logic [ADDR_W-1:0]              rd_idx_reg, rd_idx_next;  // address of read in flight
    logic                           hit_reg, hit_next;
    logic [ADDR_W-1:0]              idx_reg, idx_next;
    logic [isettab_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [isettab_pkg::POS_W-1:0]  res_pos_reg, res_pos_next;

    // output register
    logic [isettab_pkg::STAT_W-1:0] status_reg, status_next;
    logic                           found_reg, found_next;
    logic [isettab_pkg::POS_W-1:0]  position_reg, position_next;
    logic [isettab_pkg::ELEM_W-1:0] elem_reg, elem_next;

    logic match;

    assign in_stall      = (state_reg != isettab_pkg::S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign position      = position_reg;
    assign element_count = elem_reg;

    // compare of the previous cycle's read against the requested value
    assign match = rd_pend_reg && (rd_data_reg == value_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isettab_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg     <= opcode_next;
        value_reg      <= value_next;
        scan_reg       <= scan_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        position_reg   <= position_next;
        elem_reg       <= elem_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        rd_pend_next    = rd_pend_reg;
        opcode_next     = opcode_reg;
        value_next      = value_reg;
        scan_next       = scan_reg;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        position_next   = position_reg;
        elem_next       = elem_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            isettab_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    opcode_next  = opcode;
                    value_next   = $unsigned(value);
                    scan_next    = '0;
                    rd_pend_next = 1'b0;
                    state_next   = isettab_pkg::S_SEARCH;
                end
            end

            // read one entry per cycle, compare the one read last cycle
            isettab_pkg::S_SEARCH:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    idx_next     = rd_idx_reg;
                    rd_pend_next = 1'b0;
                    state_next   = isettab_pkg::S_EXEC;
                end
                else if (scan_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = scan_reg[ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_reg[ADDR_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                end
                else
                begin
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = isettab_pkg::S_EXEC;
                end
            end

            isettab_pkg::S_EXEC:
            begin
                state_next = isettab_pkg::S_FINISH;
                case (opcode_reg)
                    isettab_pkg::OP_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = isettab_pkg::ST_PRESENT;
                            res_pos_next    = isettab_pkg::POS_W'(idx_reg);
                        end
                        else if (count_reg == CNT_W'(isettab_pkg::DEPTH))
                        begin
                            res_status_next = isettab_pkg::ST_FULL;
                            res_pos_next    = '0;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = count_reg[ADDR_W-1:0];
                            mem_wdata       = value_reg;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = isettab_pkg::ST_OK;
                            res_pos_next    = isettab_pkg::POS_W'(count_reg[ADDR_W-1:0]);
                        end
                    end
                    isettab_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = isettab_pkg::ST_OK;
                            res_pos_next    = isettab_pkg::POS_W'(idx_reg);
                            scan_next       = CNT_W'(idx_reg) + CNT_W'(1);
                            rd_pend_next    = 1'b0;
                            state_next      = isettab_pkg::S_SHIFT;
                        end
                        else
                        begin
                            res_status_next = isettab_pkg::ST_MISSING;
                            res_pos_next    = '0;
                        end
                    end
                    default:
                    begin
                        // lookup, and the unused code
                        if (hit_reg)
                        begin
                            res_status_next = isettab_pkg::ST_OK;
                            res_pos_next    = isettab_pkg::POS_W'(idx_reg);
                        end
                        else
                        begin
                            res_status_next = isettab_pkg::ST_MISSING;
                            res_pos_next    = '0;
                        end
                    end
                endcase
            end

            // move entries above the hole down one place: read i, write i-1
            isettab_pkg::S_SHIFT:
            begin
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg - ADDR_W'(1);
                    mem_wdata = rd_data_reg;
                end
                if (scan_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = scan_reg[ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_reg[ADDR_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = isettab_pkg::S_FINISH;
                    end
                end
            end

            // hand the result to the output register once it is free
            isettab_pkg::S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = hit_reg;
                    position_next  = res_pos_reg;
                    elem_next      = isettab_pkg::ELEM_W'(count_reg);
                    state_next     = isettab_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = isettab_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(isettab_pkg::DEPTH))
        else $error("element count above store depth");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == isettab_pkg::S_FINISH))
        else $error("result raised outside finish step");

    a_shift_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == isettab_pkg::S_SHIFT)
            |-> (CNT_W'(mem_waddr) < count_reg - CNT_W'(1)))
        else $error("shift write beyond live entries");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isettab_pkg::S_IDLE && !in_valid) |=> state_reg == isettab_pkg::S_IDLE)
        else $error("sequencer left idle without an item");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isettab_pkg::S_SEARCH || state_reg == isettab_pkg::S_FINISH)
            |=> $stable(count_reg))
        else $error("count changed outside add or remove");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the integer set table
// Drives lookup, add and remove requests through the valid/stall request
// channel and checks every result item field by field against an in-bench
// model of the ordered set. A short table of hand-picked requests comes
// first, then random traffic under four idle/stall mixes, then a fill of
// the whole store to exercise the full and shift-from-head cases.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = isettab_pkg::DEPTH;
    localparam int OP_W   = isettab_pkg::OP_W;
    localparam int VAL_W  = isettab_pkg::VAL_W;
    localparam int STAT_W = isettab_pkg::STAT_W;
    localparam int POS_W  = isettab_pkg::POS_W;
    localparam int ELEM_W = isettab_pkg::ELEM_W;

    localparam logic [OP_W-1:0]   OP_LOOKUP  = isettab_pkg::OP_LOOKUP;
    localparam logic [OP_W-1:0]   OP_ADD     = isettab_pkg::OP_ADD;
    localparam logic [OP_W-1:0]   OP_REMOVE  = isettab_pkg::OP_REMOVE;
    localparam logic [STAT_W-1:0] ST_OK      = isettab_pkg::ST_OK;
    localparam logic [STAT_W-1:0] ST_PRESENT = isettab_pkg::ST_PRESENT;
    localparam logic [STAT_W-1:0] ST_MISSING = isettab_pkg::ST_MISSING;
    localparam logic [STAT_W-1:0] ST_FULL    = isettab_pkg::ST_FULL;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    // worst item: search up to the hit plus shift of the rest,
    // stretched by sender gaps and receiver stalls
    localparam int WATCHDOG_LIMIT = 20 * DEPTH;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int ITEMS_PER_MIX  = 72;
    localparam int POOL_SIZE      = 16;
    localparam int NO_ENTRY       = -1;

    // the fourth opcode is not decoded by the block and behaves as a lookup
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // one result item as seen on the result channel
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element_count;
    } set_result_t;

    // one row of the directed table; a typed result is used as is,
    // otherwise the set model supplies the expectation
    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        set_result_t             result;
    } request_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block interface
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [OP_W-1:0]         opcode = OP_LOOKUP;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic [ELEM_W-1:0]       element_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    integer_set_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .position      (position),
        .element_count (element_count)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // model of the store: entries below set_size are valid, in insertion order
    logic signed [VAL_W-1:0] set_mem [DEPTH];
    int                      set_size = 0;
    int                      peak_size = 0;

    set_result_t             pending_results [$];
    int                      error_count = 0;
    int                      requests_sent = 0;
    int                      results_checked = 0;
    int                      status_seen [4] = '{0, 0, 0, 0};

    // idle mix, in percent of cycles
    int                      send_idle_pct = 0;
    int                      stall_pct = 0;

    logic signed [VAL_W-1:0] value_pool [POOL_SIZE];

    // Directed table. Row order matters: each row sees the set left by the
    // rows above it. Comments show the set contents after the row.
    request_row_t dir_rows [23] = '{
        // empty store right after reset
        '{OP_LOOKUP, 32'sh0000_0000, 1'b1, '{ST_MISSING, 1'b0, 10'd0, 11'd0}},
        '{OP_REMOVE, 32'sh0000_0005, 1'b1, '{ST_MISSING, 1'b0, 10'd0, 11'd0}},
        // append the extremes, zero and all-ones: [min max 0 -1]
        '{OP_ADD,    32'sh8000_0000, 1'b1, '{ST_OK,      1'b0, 10'd0, 11'd1}},
        '{OP_ADD,    32'sh7FFF_FFFF, 1'b1, '{ST_OK,      1'b0, 10'd1, 11'd2}},
        '{OP_ADD,    32'sh0000_0000, 1'b1, '{ST_OK,      1'b0, 10'd2, 11'd3}},
        '{OP_ADD,    32'shFFFF_FFFF, 1'b1, '{ST_OK,      1'b0, 10'd3, 11'd4}},
        // duplicate add reports the existing slot
        '{OP_ADD,    32'sh7FFF_FFFF, 1'b1, '{ST_PRESENT, 1'b1, 10'd1, 11'd4}},
        '{OP_LOOKUP, 32'sh8000_0000, 1'b1, '{ST_OK,      1'b1, 10'd0, 11'd4}},
        // spare opcode, hit and miss
        '{OP_SPARE,  32'shFFFF_FFFF, 1'b1, '{ST_OK,      1'b1, 10'd3, 11'd4}},
        '{OP_SPARE,  32'sh0000_3039, 1'b1, '{ST_MISSING, 1'b0, 10'd0, 11'd4}},
        '{OP_LOOKUP, 32'sh0000_0001, 1'b1, '{ST_MISSING, 1'b0, 10'd0, 11'd4}},
        // remove from the middle, later entries move down: [min 0 -1]
        '{OP_REMOVE, 32'sh7FFF_FFFF, 1'b1, '{ST_OK,      1'b1, 10'd1, 11'd3}},
        '{OP_LOOKUP, 32'shFFFF_FFFF, 1'b1, '{ST_OK,      1'b1, 10'd2, 11'd3}},
        '{OP_REMOVE, 32'sh0000_0007, 1'b1, '{ST_MISSING, 1'b0, 10'd0, 11'd3}},
        // remove head, then tail: [0]
        '{OP_REMOVE, 32'sh8000_0000, 1'b1, '{ST_OK,      1'b1, 10'd0, 11'd2}},
        '{OP_REMOVE, 32'shFFFF_FFFF, 1'b1, '{ST_OK,      1'b1, 10'd1, 11'd1}},
        // alternating bit patterns: [0 55.. AA..]
        '{OP_ADD,    32'sh5555_5555, 1'b0, '0},
        '{OP_ADD,    32'shAAAA_AAAA, 1'b0, '0},
        '{OP_LOOKUP, 32'shAAAA_AAAA, 1'b0, '0},
        '{OP_REMOVE, 32'sh0000_0000, 1'b1, '{ST_OK,      1'b1, 10'd0, 11'd2}},
        '{OP_REMOVE, 32'sh5555_5555, 1'b0, '0},
        '{OP_ADD,    32'sh5555_5555, 1'b0, '0},
        '{OP_REMOVE, 32'shAAAA_AAAA, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // set model
    // ------------------------------------------------------------------------
    // lowest valid index holding val, NO_ENTRY if absent
    function automatic int find_entry(input logic signed [VAL_W-1:0] val);
        for (int i = 0; i < set_size; i++)
            if (set_mem[i] == val)
                return i;
        return NO_ENTRY;
    endfunction

    // applies one request to the model and returns the result it produces
    function automatic set_result_t apply_set_op(input logic [OP_W-1:0] op,
                                                 input logic signed [VAL_W-1:0] val);
        set_result_t r;
        int          idx;
        int          pos;
        bit          hit;
        idx = find_entry(val);
        hit = (idx != NO_ENTRY);
        pos = 0;
        r   = '0;
        case (op)
            OP_ADD:
            begin
                if (hit)
                begin
                    r.status = ST_PRESENT;
                    pos      = idx;
                end
                else if (set_size >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    set_mem[set_size] = val;
                    pos               = set_size;
                    set_size++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    // close the gap, keeping order
                    set_size--;
                    for (int i = idx; i < set_size; i++)
                        set_mem[i] = set_mem[i + 1];
                    pos      = idx;
                    r.status = ST_OK;
                end
                else
                    r.status = ST_MISSING;
            end
            default:
            begin
                // lookup, and the spare code
                r.status = hit ? ST_OK : ST_MISSING;
                pos      = hit ? idx : 0;
            end
        endcase
        r.found         = hit;
        r.position      = POS_W'(pos);
        r.element_count = ELEM_W'(set_size);
        return r;
    endfunction

    // random value that is not in the set
    function automatic logic signed [VAL_W-1:0] fresh_value();
        logic signed [VAL_W-1:0] v;
        do
            v = $urandom;
        while (find_entry(v) != NO_ENTRY);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    // Presents one item, holds it until accepted, logs the expected result,
    // then maybe idles. Valid stays high between back-to-back items so it
    // never sees two assignments at one edge.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [VAL_W-1:0] val,
                                input bit typed,
                                input set_result_t typed_result);
        set_result_t predicted;
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        // accepted at this edge
        predicted = apply_set_op(op, val);
        if (typed)
            predicted = typed_result;
        pending_results.push_back(predicted);
        status_seen[predicted.status]++;
        requests_sent++;
        if (set_size > peak_size)
            peak_size = set_size;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Random request. Values mostly come from a small pool so that hits,
    // duplicates and removes are common; the rest are full-range randoms.
    task automatic send_random_request();
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        int                      pick;
        pick = $urandom_range(99);
        if (pick < 30)
            op = OP_LOOKUP;
        else if (pick < 65)
            op = OP_ADD;
        else if (pick < 95)
            op = OP_REMOVE;
        else
            op = OP_SPARE;
        if ($urandom_range(99) < 75)
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            val = $urandom;
        send_request(op, val, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH result %0d: %s", $time, results_checked, what);
        error_count++;
    endtask

    // random back-pressure at the configured rate
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        set_result_t got;
        set_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status, found, position, element_count};
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", got));
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, got.status));
                if (got.found !== want.found)
                    report_mismatch($sformatf("found expected %0d, got %0d",
                                              want.found, got.found));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position expected %0d, got %0d",
                                              want.position, got.position));
                if (got.element_count !== want.element_count)
                    report_mismatch($sformatf("element_count expected %0d, got %0d",
                                              want.element_count, got.element_count));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves on either channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequence_main
        // pool: extremes, zero, all-ones, one, and a few random values
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = 32'shFFFF_FFFF;
        value_pool[4] = 32'sh0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].val,
                         dir_rows[i].typed, dir_rows[i].result);

        // random traffic under each idle mix: none, sender gaps,
        // receiver stalls, then a light mix of both
        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (ITEMS_PER_MIX)
                send_random_request();
        end

        // Fill the whole store. Slow by nature (search grows with the set),
        // so it runs without idling.
        send_idle_pct = 0;
        stall_pct     = 0;
        while (set_size < DEPTH)
            send_request(OP_ADD, fresh_value(), 1'b0, '0);
        // add to a full store is refused and changes nothing
        send_request(OP_ADD, fresh_value(), 1'b1,
                     '{ST_FULL, 1'b0, 10'd0, ELEM_W'(DEPTH)});
        send_request(OP_LOOKUP, set_mem[DEPTH - 1], 1'b0, '0);
        send_request(OP_ADD, set_mem[0], 1'b0, '0);
        // removing the head shifts every other entry down
        send_request(OP_REMOVE, set_mem[0], 1'b0, '0);
        send_request(OP_ADD, fresh_value(), 1'b0, '0);
        send_request(OP_ADD, fresh_value(), 1'b0, '0);
        send_request(OP_REMOVE, set_mem[DEPTH - 1], 1'b0, '0);
        in_valid <= 1'b0;

        // let every result arrive, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));

        $display("Run covered %0d requests and %0d results (ok %0d, present %0d, missing %0d,",
                 requests_sent, results_checked, status_seen[ST_OK],
                 status_seen[ST_PRESENT], status_seen[ST_MISSING]);
        $display("  full %0d); set grew to %0d of %0d entries; %0d mismatches.",
                 status_seen[ST_FULL], peak_size, DEPTH, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ integer_set_table.f @@
rtl/isettab_pkg.sv
rtl/integer_set_table.sv
verif/tb_top.sv
